[hdl/cc20_pkg.sv]
// Shared types, constants and the quarter-round function for the ChaCha20 block.
package cc20_pkg;

    localparam int ROUND_COUNT = 20;
    localparam int ROUND_W     = $clog2(ROUND_COUNT);
    localparam int KEY_REGS    = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int PAIRS       = 8;
    localparam int PAIR_W      = $clog2(PAIRS);

    typedef logic [31:0]          word_t;
    typedef logic [15:0][31:0]    matrix_t;
    typedef logic [3:0]           widx_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_PAIR_0 = 3'd0,
        REG_KEY_PAIR_1 = 3'd1,
        REG_KEY_PAIR_2 = 3'd2,
        REG_KEY_PAIR_3 = 3'd3
    } cfg_reg_t;

    localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

    // [pass][lane][a,b,c,d]; pass 0 = column, pass 1 = diagonal
    localparam widx_t LANES [2][4][4] = '{
        '{'{4'd0, 4'd4, 4'd8,  4'd12}, '{4'd1, 4'd5, 4'd9,  4'd13},
          '{4'd2, 4'd6, 4'd10, 4'd14}, '{4'd3, 4'd7, 4'd11, 4'd15}},
        '{'{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd1, 4'd6, 4'd11, 4'd12},
          '{4'd2, 4'd7, 4'd8,  4'd13}, '{4'd3, 4'd4, 4'd9,  4'd14}}
    };

    typedef struct packed {
        word_t nonce_word_2;
        word_t nonce_word_1;
        word_t nonce_word_0;
        word_t block_counter;
    } in_item_t;

    typedef struct packed {
        logic [63:0]       word_pair;
        logic [PAIR_W-1:0] pair_index;
        logic              last_pair;
    } out_item_t;

    typedef struct packed {
        logic              load;
        logic              round_en;
        logic              diag;
        logic              emit;
        logic [PAIR_W-1:0] pair_sel;
    } cc20_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_EMIT
    } cc20_state_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    function automatic word_t rotl(input word_t v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic quad_t quarter_round(input quad_t q);
        quad_t r;
        r = q;
        r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 16);
        r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 12);
        r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 8);
        r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 7);
        quarter_round = r;
    endfunction

endpackage

[hdl/chacha20_keystream_block.sv]
// ChaCha20 keystream block: 20 rounds, one round per cycle, four quarter-round units.
// After load and 20 rounds, the result register shows one pair per cycle.
// A new item is taken only when idle: after load, 20 rounds and the emit of all 8 pairs.
// busy drops as the last pair is registered; the next item may start while it shows.
// Results cannot be stalled: each pair is valid for exactly one cycle.
// rst_n clears the sequencer and zeroes the key registers.
module chacha20_keystream_block
    import cc20_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  in_item_t               item,
    output logic                   busy,
    output logic                   result_valid,
    output out_item_t              result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data
);

    cc20_cmd_t cmd;

    assign cfg_ready = 1'b1;

    cc20_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    cc20_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

[hdl/cc20_ctrl.sv]
// Sequencer: load, round iterations and pair emission.
module cc20_ctrl
    import cc20_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      result_valid,
    output cc20_cmd_t cmd
);

    cc20_state_t        state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [PAIR_W-1:0]  pair_reg, pair_next;
    logic               valid_reg;
    logic               last_round;
    logic               last_emit;

    assign last_round = (round_reg == ROUND_W'(ROUND_COUNT - 1));
    assign last_emit  = (pair_reg == PAIR_W'(PAIRS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (last_round)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (last_emit)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        busy       = 1'b1;
        round_next = round_reg;
        pair_next  = pair_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.load   = start;
                round_next = '0;
                pair_next  = '0;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                cmd.diag     = round_reg[0];
                round_next   = round_reg + 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit     = 1'b1;
                cmd.pair_sel = pair_reg;
                pair_next    = pair_reg + 1'b1;
            end
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            pair_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            pair_reg  <= pair_next;
            valid_reg <= cmd.emit;
        end
    end

    assign result_valid = valid_reg;

endmodule

[hdl/cc20_datapath.sv]
// Key registers, state matrices, four quarter-round units and result register.
module cc20_datapath
    import cc20_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cc20_cmd_t              cmd,
    input  in_item_t               item,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    output out_item_t              result
);

    logic [KEY_REGS-1:0][63:0] key_reg;
    matrix_t                   init_reg;
    matrix_t                   work_reg, work_next;
    matrix_t                   load_mat;
    out_item_t                 result_reg, result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_PAIR_0: key_reg[0] <= cfg_data;
                REG_KEY_PAIR_1: key_reg[1] <= cfg_data;
                REG_KEY_PAIR_2: key_reg[2] <= cfg_data;
                REG_KEY_PAIR_3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            load_mat[i]         = SIGMA[i];
            load_mat[4 + 2 * i] = key_reg[i][31:0];
            load_mat[5 + 2 * i] = key_reg[i][63:32];
        end
        load_mat[12] = item.block_counter;
        load_mat[13] = item.nonce_word_0;
        load_mat[14] = item.nonce_word_1;
        load_mat[15] = item.nonce_word_2;
    end

    // one column or diagonal pass per cycle while round_en is set; the four lanes touch disjoint words
    always_comb
    begin
        quad_t q;
        quad_t r;
        work_next = work_reg;
        for (int i = 0; i < 4; i++)
        begin
            q.a = work_reg[LANES[cmd.diag][i][0]];
            q.b = work_reg[LANES[cmd.diag][i][1]];
            q.c = work_reg[LANES[cmd.diag][i][2]];
            q.d = work_reg[LANES[cmd.diag][i][3]];
            r   = quarter_round(q);
            work_next[LANES[cmd.diag][i][0]] = r.a;
            work_next[LANES[cmd.diag][i][1]] = r.b;
            work_next[LANES[cmd.diag][i][2]] = r.c;
            work_next[LANES[cmd.diag][i][3]] = r.d;
        end
    end

    always_comb
    begin
        widx_t lo;
        widx_t hi;
        lo = {cmd.pair_sel, 1'b0};
        hi = {cmd.pair_sel, 1'b1};
        result_next.word_pair  = {work_reg[hi] + init_reg[hi], work_reg[lo] + init_reg[lo]};
        result_next.pair_index = cmd.pair_sel;
        result_next.last_pair  = (cmd.pair_sel == PAIR_W'(PAIRS - 1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            init_reg <= load_mat;
            work_reg <= load_mat;
        end
        else if (cmd.round_en)
            work_reg <= work_next;
        if (cmd.emit)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule
